// ===== hw/rtl/dual_square_sound_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the dual square sound unit
// Shared property wrappers used by the checker.
// ----------------------------------------------------------------------------
`ifndef DUAL_SQUARE_SOUND_UNIT_MACROS_SVH
`define DUAL_SQUARE_SOUND_UNIT_MACROS_SVH

// Plain property, sampled on the rising clock, off while in reset
`define DSSU_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Signal holds its value in the cycle after the condition
`define DSSU_ASSERT_HOLD(name, clk, rst_n, cond, sig, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> $stable(sig)) \
    else $error(msg);

`endif

// ===== hw/rtl/dssu_pkg.sv =====
// ----------------------------------------------------------------------------
// Dual square sound unit package
// Types, register map, opcodes and lookup tables shared by the RTL.
// ----------------------------------------------------------------------------
`default_nettype none

package dssu_pkg;

  // Item opcodes
  typedef enum logic [1:0] {
    OP_WRITE   = 2'd0,
    OP_READ    = 2'd1,
    OP_ADVANCE = 2'd2
  } opcode_e;

  // Per-channel register select
  typedef enum logic [1:0] {
    REG_CTRL      = 2'd0,
    REG_PERIOD_LO = 2'd1,
    REG_PERIOD_HI = 2'd2,
    REG_ENABLE    = 2'd3
  } chan_reg_e;

  // Register map
  localparam logic [15:0] ADDR_CH0_CTRL      = 16'h5000;
  localparam logic [15:0] ADDR_CH0_PERIOD_LO = 16'h5002;
  localparam logic [15:0] ADDR_CH0_PERIOD_HI = 16'h5003;
  localparam logic [15:0] ADDR_CH1_CTRL      = 16'h5004;
  localparam logic [15:0] ADDR_CH1_PERIOD_LO = 16'h5006;
  localparam logic [15:0] ADDR_CH1_PERIOD_HI = 16'h5007;
  localparam logic [15:0] ADDR_DIRECT_RD     = 16'h5010;
  localparam logic [15:0] ADDR_DIRECT_WR     = 16'h5011;
  localparam logic [15:0] ADDR_STATUS        = 16'h5015;

  // Timing constants
  localparam logic [13:0] FRAME_TICK_PERIOD = 14'd7457;
  localparam logic [4:0]  MAX_STEP_CYCLES   = 5'd16;
  localparam logic [10:0] MIN_PERIOD        = 11'd8;
  localparam logic [3:0]  VOLUME_MAX        = 4'hF;

  // Command word from the decoder to one channel
  typedef struct packed {
    logic      wr;
    chan_reg_e sel;
    logic [7:0] data;
    logic      adv;
    logic [4:0] cyc;
  } chan_cmd_t;

  // Length counter load values
  function automatic logic [7:0] length_lookup(input logic [4:0] idx);
    logic [7:0] val;
    case (idx)
      5'd0:  val = 8'd10;
      5'd1:  val = 8'd254;
      5'd2:  val = 8'd20;
      5'd3:  val = 8'd2;
      5'd4:  val = 8'd40;
      5'd5:  val = 8'd4;
      5'd6:  val = 8'd80;
      5'd7:  val = 8'd6;
      5'd8:  val = 8'd160;
      5'd9:  val = 8'd8;
      5'd10: val = 8'd60;
      5'd11: val = 8'd10;
      5'd12: val = 8'd14;
      5'd13: val = 8'd12;
      5'd14: val = 8'd26;
      5'd15: val = 8'd14;
      5'd16: val = 8'd12;
      5'd17: val = 8'd16;
      5'd18: val = 8'd24;
      5'd19: val = 8'd18;
      5'd20: val = 8'd48;
      5'd21: val = 8'd20;
      5'd22: val = 8'd96;
      5'd23: val = 8'd22;
      5'd24: val = 8'd192;
      5'd25: val = 8'd24;
      5'd26: val = 8'd72;
      5'd27: val = 8'd26;
      5'd28: val = 8'd16;
      5'd29: val = 8'd28;
      5'd30: val = 8'd32;
      5'd31: val = 8'd30;
      default: val = 8'd0;
    endcase
    return val;
  endfunction

  // Duty waveform: bit k high means step k outputs the positive level
  function automatic logic duty_bit(input logic [1:0] sel, input logic [2:0] step);
    logic [7:0] pat;
    case (sel)
      2'd0: pat = 8'h02;
      2'd1: pat = 8'h06;
      2'd2: pat = 8'h1E;
      2'd3: pat = 8'hF9;
      default: pat = 8'h00;
    endcase
    return pat[step];
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/dssu_in_if.sv =====
// ----------------------------------------------------------------------------
// Input channel interface
// Valid/ready channel carrying one command word per handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface dssu_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [15:0] address;
  logic [7:0]  write_data;
  logic [4:0]  cycles;

  modport source (output valid, opcode, address, write_data, cycles, input ready);
  modport sink   (input valid, opcode, address, write_data, cycles, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/dssu_out_if.sv =====
// ----------------------------------------------------------------------------
// Output channel interface
// Valid/ready channel carrying one result word per handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface dssu_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;
  logic [7:0]         read_data;
  logic               read_hit;

  modport source (output valid, sample, read_data, read_hit, input ready);
  modport sink   (input valid, sample, read_data, read_hit, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/dssu_channel.sv =====
// ----------------------------------------------------------------------------
// Square channel
// Register state, duty sequencer, envelope and length counter of one channel.
// All updates for one command word are computed combinationally and registered together.
// ----------------------------------------------------------------------------
`default_nettype none

module dssu_channel (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire dssu_pkg::chan_cmd_t cmd_i,
  output logic signed [6:0]     level_o,
  output logic                  length_nz_o
);

  logic [3:0]         fv_q, fv_d;
  logic               cm_q, cm_d;
  logic               hl_q, hl_d;
  logic [1:0]         duty_q, duty_d;
  logic [10:0]        per_q, per_d;
  logic [3:0]         cv_q, cv_d;
  logic [2:0]         step_q, step_d;
  logic [8:0]         len_q, len_d;
  logic [4:0]         dd_q, dd_d;
  logic [3:0]         dl_q, dl_d;
  logic               en_q, en_d;
  logic               act_q, act_d;
  logic               rs_q, rs_d;
  logic signed [13:0] pc_q, pc_d;
  logic signed [13:0] fc_q, fc_d;

  logic signed [13:0] cyc_s;
  logic signed [13:0] pc_sub;
  logic signed [13:0] fc_sub;
  logic signed [13:0] pc_reload;
  logic [4:0]         dd_dec;
  logic [4:0]         dd_reload;
  logic [6:0]         vol_x4;

  assign cyc_s     = $signed({9'd0, cmd_i.cyc});
  assign pc_sub    = pc_q - cyc_s;
  assign fc_sub    = fc_q - cyc_s;
  assign pc_reload = $signed({1'b0, ({1'b0, per_q} + 12'd1), 1'b0});
  assign dd_dec    = dd_q - 5'd1;
  assign dd_reload = {1'b0, fv_q} + 5'd1;

  assign length_nz_o = (len_q != 9'd0);

  // Next state for register writes and advance
  always_comb begin
    fv_d    = fv_q;
    cm_d    = cm_q;
    hl_d    = hl_q;
    duty_d  = duty_q;
    per_d   = per_q;
    cv_d    = cv_q;
    step_d  = step_q;
    len_d   = len_q;
    dd_d    = dd_q;
    dl_d    = dl_q;
    en_d    = en_q;
    act_d   = act_q;
    rs_d    = rs_q;
    pc_d    = pc_q;
    fc_d    = fc_q;
    vol_x4  = '0;
    level_o = '0;

    if (cmd_i.wr) begin
      case (cmd_i.sel)
        dssu_pkg::REG_CTRL: begin
          fv_d   = cmd_i.data[3:0];
          cm_d   = cmd_i.data[4];
          hl_d   = cmd_i.data[5];
          duty_d = cmd_i.data[7:6];
          cv_d   = cmd_i.data[4] ? cmd_i.data[3:0] : dl_q;
        end
        dssu_pkg::REG_PERIOD_LO: begin
          per_d = {per_q[10:8], cmd_i.data};
        end
        dssu_pkg::REG_PERIOD_HI: begin
          per_d = {cmd_i.data[2:0], per_q[7:0]};
          if (en_q) begin
            len_d = {dssu_pkg::length_lookup(cmd_i.data[7:3]), 1'b0};
          end
          step_d = 3'd0;
          rs_d   = 1'b1;
        end
        dssu_pkg::REG_ENABLE: begin
          en_d = |cmd_i.data;
          if (!(|cmd_i.data)) begin
            len_d = 9'd0;
          end
        end
        default: begin
          en_d = en_q;
        end
      endcase
      act_d = (per_d >= dssu_pkg::MIN_PERIOD) && (len_d != 9'd0);
    end else if (cmd_i.adv && en_q && act_q) begin
      // duty sequencer: period >= 8 keeps this to one wrap
      if (pc_sub <= 14'sd0) begin
        pc_d   = pc_sub + pc_reload;
        step_d = step_q + 3'd1;
      end else begin
        pc_d = pc_sub;
      end
      // frame tick: envelope and length counter
      if (fc_sub <= 14'sd0) begin
        fc_d = fc_sub + $signed(dssu_pkg::FRAME_TICK_PERIOD);
        if (rs_q) begin
          rs_d = 1'b0;
          dl_d = dssu_pkg::VOLUME_MAX;
          dd_d = dd_reload;
        end else if (dd_dec == 5'd0) begin
          dd_d = dd_reload;
          if (dl_q != 4'd0) begin
            dl_d = dl_q - 4'd1;
          end else begin
            dl_d = hl_q ? dssu_pkg::VOLUME_MAX : 4'd0;
          end
        end else begin
          dd_d = dd_dec;
        end
        if ((len_q != 9'd0) && !hl_q) begin
          len_d = len_q - 9'd1;
        end
      end else begin
        fc_d = fc_sub;
      end
      cv_d   = cm_q ? fv_q : dl_d;
      act_d  = (per_q >= dssu_pkg::MIN_PERIOD) && (len_d != 9'd0);
      vol_x4 = {1'b0, cv_d, 2'b00};
      if (act_d) begin
        level_o = dssu_pkg::duty_bit(duty_q, step_d) ? $signed(vol_x4) : -$signed(vol_x4);
      end
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q   <= '0;
      cm_q   <= 1'b0;
      hl_q   <= 1'b0;
      duty_q <= '0;
      per_q  <= '0;
      cv_q   <= '0;
      step_q <= '0;
      len_q  <= '0;
      dd_q   <= '0;
      dl_q   <= '0;
      en_q   <= 1'b0;
      act_q  <= 1'b0;
      rs_q   <= 1'b0;
      pc_q   <= 14'sd1;
      fc_q   <= 14'sd0;
    end else begin
      fv_q   <= fv_d;
      cm_q   <= cm_d;
      hl_q   <= hl_d;
      duty_q <= duty_d;
      per_q  <= per_d;
      cv_q   <= cv_d;
      step_q <= step_d;
      len_q  <= len_d;
      dd_q   <= dd_d;
      dl_q   <= dl_d;
      en_q   <= en_d;
      act_q  <= act_d;
      rs_q   <= rs_d;
      pc_q   <= pc_d;
      fc_q   <= fc_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/dual_square_sound_unit.sv =====
// ----------------------------------------------------------------------------
// Dual square sound unit
// Pipe: an accepted input word enters the input register; its result word is
// then captured in the result register, as channel state is updated.
// Throughput: one word per cycle while the result register is not stalled by
// out_o.ready; the input register and the result register form a two-stage pipe.
// Reset: asynchronous, active low; clears all channel state, the direct
// level and the valid flags of both pipe stages.
// ----------------------------------------------------------------------------
`default_nettype none

module dual_square_sound_unit (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  dssu_in_if.sink    in_i,
  dssu_out_if.source out_o
);

  // Input stage
  logic        s1_valid_q;
  logic [1:0]  op_q;
  logic [15:0] addr_q;
  logic [7:0]  wdata_q;
  logic [4:0]  cyc_q;

  // Result stage
  logic               out_valid_q;
  logic signed [15:0] sample_q, sample_d;
  logic [7:0]         rdata_q, rdata_d;
  logic               hit_q, hit_d;

  logic [7:0] direct_q, direct_d;

  logic                s1_adv;
  logic                is_write;
  logic                is_adv;
  logic [4:0]          cyc_clamped;
  dssu_pkg::chan_cmd_t cmd0, cmd1;
  logic signed [6:0]   level0, level1;
  logic                nz0, nz1;
  logic signed [9:0]   mix;

  // Handshake
  assign s1_adv     = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_adv;

  assign is_write    = s1_adv && (op_q == dssu_pkg::OP_WRITE);
  assign is_adv      = s1_adv && (op_q == dssu_pkg::OP_ADVANCE);
  assign cyc_clamped = (cyc_q > dssu_pkg::MAX_STEP_CYCLES) ? dssu_pkg::MAX_STEP_CYCLES : cyc_q;

  // Address decode into channel commands
  always_comb begin
    cmd0      = '0;
    cmd1      = '0;
    cmd0.adv  = is_adv;
    cmd1.adv  = is_adv;
    cmd0.cyc  = cyc_clamped;
    cmd1.cyc  = cyc_clamped;
    cmd0.data = wdata_q;
    cmd1.data = wdata_q;
    direct_d  = direct_q;
    if (is_write) begin
      case (addr_q)
        dssu_pkg::ADDR_CH0_CTRL: begin
          cmd0.wr  = 1'b1;
          cmd0.sel = dssu_pkg::REG_CTRL;
        end
        dssu_pkg::ADDR_CH0_PERIOD_LO: begin
          cmd0.wr  = 1'b1;
          cmd0.sel = dssu_pkg::REG_PERIOD_LO;
        end
        dssu_pkg::ADDR_CH0_PERIOD_HI: begin
          cmd0.wr  = 1'b1;
          cmd0.sel = dssu_pkg::REG_PERIOD_HI;
        end
        dssu_pkg::ADDR_CH1_CTRL: begin
          cmd1.wr  = 1'b1;
          cmd1.sel = dssu_pkg::REG_CTRL;
        end
        dssu_pkg::ADDR_CH1_PERIOD_LO: begin
          cmd1.wr  = 1'b1;
          cmd1.sel = dssu_pkg::REG_PERIOD_LO;
        end
        dssu_pkg::ADDR_CH1_PERIOD_HI: begin
          cmd1.wr  = 1'b1;
          cmd1.sel = dssu_pkg::REG_PERIOD_HI;
        end
        dssu_pkg::ADDR_DIRECT_WR: begin
          direct_d = wdata_q;
        end
        dssu_pkg::ADDR_STATUS: begin
          cmd0.wr   = 1'b1;
          cmd0.sel  = dssu_pkg::REG_ENABLE;
          cmd0.data = {7'd0, wdata_q[0]};
          cmd1.wr   = 1'b1;
          cmd1.sel  = dssu_pkg::REG_ENABLE;
          cmd1.data = {6'd0, wdata_q[1], 1'b0};
        end
        default: begin
          direct_d = direct_q;
        end
      endcase
    end
  end

  dssu_channel u_ch0 (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd0),
    .level_o     (level0),
    .length_nz_o (nz0)
  );

  dssu_channel u_ch1 (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd1),
    .level_o     (level1),
    .length_nz_o (nz1)
  );

  // Mix and read-back
  assign mix = $signed({{3{level0[6]}}, level0}) + $signed({{3{level1[6]}}, level1})
             + $signed({2'b00, direct_q});

  always_comb begin
    sample_d = '0;
    rdata_d  = '0;
    hit_d    = 1'b0;
    case (op_q)
      dssu_pkg::OP_READ: begin
        if (addr_q == dssu_pkg::ADDR_DIRECT_RD) begin
          rdata_d = direct_q;
          hit_d   = 1'b1;
        end else if (addr_q == dssu_pkg::ADDR_STATUS) begin
          rdata_d = {6'd0, nz1, nz0};
          hit_d   = 1'b1;
        end
      end
      dssu_pkg::OP_ADVANCE: begin
        sample_d = {mix, 6'd0};
      end
      default: begin
        hit_d = 1'b0;
      end
    endcase
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      op_q    <= in_i.opcode;
      addr_q  <= in_i.address;
      wdata_q <= in_i.write_data;
      cyc_q   <= in_i.cycles;
    end
  end

  // Direct level and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      direct_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      direct_q <= direct_d;
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      sample_q <= sample_d;
      rdata_q  <= rdata_d;
      hit_q    <= hit_d;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.sample    = sample_q;
  assign out_o.read_data = rdata_q;
  assign out_o.read_hit  = hit_q;

endmodule

`default_nettype wire

// ===== hw/rtl/dssu_checker.sv =====
// ----------------------------------------------------------------------------
// Dual square sound unit checker
// Port-level properties of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "dual_square_sound_unit_macros.svh"

module dssu_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [15:0] sample_i,
  input wire logic [7:0]  read_data_i,
  input wire logic        read_hit_i
);

  logic        sample_clear;
  logic        read_quiet;
  logic        data_gated;
  logic        stalled;
  logic [25:0] word_w;

  assign sample_clear = (sample_i[5:0] == 6'd0);
  assign read_quiet   = !read_hit_i || (sample_i == 16'd0);
  assign data_gated   = (read_data_i == 8'd0) || read_hit_i;
  assign stalled      = out_valid_i && !out_ready_i;
  assign word_w       = {out_valid_i, sample_i, read_data_i, read_hit_i};

  // mix is scaled by 64, so the low bits are always clear
  `DSSU_ASSERT(a_sample_scaled, clk_i, rst_ni, !out_valid_i || sample_clear, "sample low bits set")

  // a read word carries no sample
  `DSSU_ASSERT(a_read_no_sample, clk_i, rst_ni, !out_valid_i || read_quiet, "sample on read word")

  // read data only on a hit
  `DSSU_ASSERT(a_data_needs_hit, clk_i, rst_ni, !out_valid_i || data_gated, "data without hit")

  // stalled word holds
  `DSSU_ASSERT_HOLD(a_stall_hold, clk_i, rst_ni, stalled, word_w, "stalled word changed")

endmodule

bind dual_square_sound_unit dssu_checker u_dssu_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .sample_i    (out_o.sample),
  .read_data_i (out_o.read_data),
  .read_hit_i  (out_o.read_hit)
);

`default_nettype wire
